@@ sv/h264d_pkg.sv @@
package h264d_pkg;

    typedef enum logic [2:0] {
        M_NONE,
        M_SKIP,
        M_STAP,
        M_FU_HDR,
        M_FU_PEND,
        M_FU_ON
    } t_mode;

    typedef enum logic [1:0] {
        PH_HI,
        PH_LO,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_PARAM,
        SRC_FRAME
    } t_src;

    localparam logic [2:0] ST_TAKEN    = 3'd0;
    localparam logic [2:0] ST_IGNORED  = 3'd1;
    localparam logic [2:0] ST_BUSY     = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    localparam logic [4:0] NAL_STAP_A  = 5'd24;
    localparam logic [4:0] NAL_FU_A    = 5'd28;
    localparam logic [7:0] HDR_IDR     = 8'h65;
    localparam logic [7:0] MASK_TYPE   = 8'h1F;
    localparam logic [7:0] MASK_NRI    = 8'hE0;

    // per-result info handed from the control stage to the output stages
    typedef struct packed {
        logic [2:0]  status;
        t_src        src;
        logic [7:0]  cbyte;
        logic [1:0]  lane;
        logic        last;
        logic [31:0] pts;
        logic        ready;
    } t_rd;

endpackage

@@ sv/h264d_ram.sv @@
module h264d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

@@ sv/h264d_ctrl.sv @@
module h264d_ctrl #(
    parameter int FRAME_BYTES = 65536,
    parameter int PARAM_BYTES = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_acc,
    input  logic                             i_kind,
    input  logic [7:0]                       i_byte,
    input  logic                             i_first,
    input  logic                             i_last,
    input  logic [31:0]                      i_ts,
    input  logic [15:0]                      i_seq,
    output h264d_pkg::t_rd                   o_rd,
    output logic [$clog2(PARAM_BYTES)-2:0]   o_prd_addr,
    output logic [$clog2(FRAME_BYTES)-1:0]   o_frd_addr,
    output logic                             o_fwe,
    output logic [$clog2(FRAME_BYTES)-1:0]   o_fwaddr,
    output logic [7:0]                       o_fwdata,
    output logic [3:0]                       o_swe,
    output logic [3:0][$clog2(PARAM_BYTES)-2:0] o_swaddr,
    output logic [3:0][7:0]                  o_swdata
);
    import h264d_pkg::*;

    localparam int FAW = $clog2(FRAME_BYTES);
    localparam int FLW = FAW + 1;
    localparam int PAW = $clog2(PARAM_BYTES);
    localparam int PLW = PAW + 1;
    localparam int RPW = ((FLW > PLW) ? FLW : PLW) + 1;
    localparam int SW  = ((PLW > 16) ? PLW : 16) + 2;

    t_mode        r_mode, n_mode;
    t_phase       r_phase, n_phase;
    logic         r_fs, n_fs, r_fce, n_fce;
    logic         r_have, n_have, r_pend, n_pend, r_ready, n_ready;
    logic         r_active, n_active, r_ref, n_ref;
    logic         r_bank, n_bank;
    logic [FLW-1:0] r_flen, n_flen;
    logic [PLW-1:0] r_plen, n_plen, r_slen, n_slen;
    logic [15:0]  r_urem, n_urem, r_lseq, n_lseq;
    logic [7:0]   r_fhdr, n_fhdr, r_frhdr, n_frhdr;
    logic [31:0]  r_fstamp, n_fstamp, r_rstamp, n_rstamp;
    logic [RPW-1:0] r_rp, n_rp;

    logic [RPW-1:0] plen, total, idx;
    logic [15:0]  ulen;
    logic [7:0]   hdr;
    logic         sw_sc, sw_data;
    logic [3:0][PAW-3:0] sc_row;
    logic [3:0][7:0] sc_dat;
    logic [1:0]   off [4];
    logic [PLW-1:0] pos [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            off[k]    = 2'(k) - r_slen[1:0];
            pos[k]    = r_slen + PLW'(off[k]);
            sc_row[k] = pos[k][PAW-1:2];
            sc_dat[k] = (off[k] == 2'd3) ? 8'h01 : 8'h00;
        end
    end

    always_comb begin
        n_mode = r_mode; n_phase = r_phase; n_fs = r_fs; n_fce = r_fce;
        n_have = r_have; n_pend = r_pend; n_ready = r_ready;
        n_active = r_active; n_ref = r_ref; n_bank = r_bank;
        n_flen = r_flen; n_plen = r_plen; n_slen = r_slen;
        n_urem = r_urem; n_lseq = r_lseq; n_fhdr = r_fhdr; n_frhdr = r_frhdr;
        n_fstamp = r_fstamp; n_rstamp = r_rstamp; n_rp = r_rp;
        o_rd = '0;
        o_rd.status = ST_IGNORED;
        o_rd.src = SRC_CONST;
        o_fwe = 1'b0;
        o_fwaddr = r_flen[FAW-1:0];
        o_fwdata = i_byte;
        sw_sc = 1'b0;
        sw_data = 1'b0;
        plen  = r_pend ? RPW'(r_plen) : '0;
        total = plen + RPW'(r_flen);
        idx   = r_rp - plen;
        ulen  = {r_urem[15:8], i_byte};
        hdr   = (r_fhdr & MASK_NRI) | (i_byte & MASK_TYPE);
        o_prd_addr = {r_bank, r_rp[PAW-1:2]};
        o_frd_addr = idx[FAW-1:0];

        if (i_kind) begin
            if (!r_ready) begin
                o_rd.status = ST_EMPTY;
            end else begin
                o_rd.status = ST_READ;
                o_rd.pts = r_fstamp - r_rstamp;
                o_rd.lane = r_rp[1:0];
                if (r_rp < plen) begin
                    o_rd.src = SRC_PARAM;
                end else if (idx < RPW'(5)) begin
                    o_rd.src = SRC_CONST;
                    o_rd.cbyte = (idx == RPW'(3)) ? 8'h01 :
                                 (idx == RPW'(4)) ? r_frhdr : 8'h00;
                end else begin
                    o_rd.src = SRC_FRAME;
                end
                if (r_rp + RPW'(1) >= total) begin
                    o_rd.last = 1'b1;
                    n_ready = 1'b0;
                    n_active = 1'b0;
                    n_pend = 1'b0;
                    n_flen = '0;
                    n_rp = '0;
                end else begin
                    n_rp = r_rp + RPW'(1);
                end
            end
        end else if (r_ready) begin
            o_rd.status = ST_BUSY;
        end else if (i_first) begin
            if (r_mode == M_FU_ON) begin
                n_active = 1'b0;
                n_flen = '0;
            end
            n_fhdr = i_byte;
            if (i_last) begin
                n_mode = M_NONE;
            end else if (i_byte[4:0] == NAL_STAP_A) begin
                n_mode = M_STAP;
                n_phase = PH_HI;
                n_slen = '0;
                n_urem = '0;
                o_rd.status = ST_TAKEN;
            end else if (i_byte[4:0] == NAL_FU_A) begin
                n_mode = M_FU_HDR;
                o_rd.status = ST_TAKEN;
            end else begin
                n_mode = M_SKIP;
            end
        end else if (r_mode != M_NONE) begin
            unique case (r_mode)
                M_STAP: begin
                    if (r_phase == PH_DATA && r_urem == '0) begin
                        n_phase = PH_HI;
                    end
                    o_rd.status = ST_TAKEN;
                    unique case (n_phase)
                        PH_HI: begin
                            n_urem = {i_byte, 8'h00};
                            n_phase = PH_LO;
                        end
                        PH_LO: begin
                            if (SW'(r_slen) + SW'(4) + SW'(ulen) > SW'(PARAM_BYTES)) begin
                                n_mode = M_SKIP;
                                o_rd.status = ST_OVERFLOW;
                            end else begin
                                sw_sc = 1'b1;
                                n_slen = r_slen + PLW'(4);
                                n_urem = ulen;
                                n_phase = PH_DATA;
                            end
                        end
                        default: begin
                            sw_data = 1'b1;
                            n_slen = r_slen + PLW'(1);
                            n_urem = r_urem - 16'd1;
                            if (r_urem == 16'd1) begin
                                n_phase = PH_HI;
                            end
                        end
                    endcase
                    if (i_last && n_mode == M_STAP) begin
                        if (n_phase == PH_HI && n_slen != '0) begin
                            // swap staging and parameter banks
                            n_plen = n_slen;
                            n_have = 1'b1;
                            n_pend = 1'b1;
                            n_bank = ~r_bank;
                        end else begin
                            o_rd.status = ST_IGNORED;
                        end
                    end
                end
                M_FU_HDR: begin
                    if (!i_last) begin
                        n_fhdr = hdr;
                        if (!r_have || (r_pend && hdr != HDR_IDR)) begin
                            n_mode = M_SKIP;
                        end else if (i_byte[7]) begin
                            n_fs = 1'b1;
                            n_fce = 1'b0;
                            n_mode = M_FU_PEND;
                            o_rd.status = ST_TAKEN;
                        end else if (!r_active || i_seq != r_lseq + 16'd1 ||
                                     i_ts != r_fstamp) begin
                            n_mode = M_SKIP;
                        end else begin
                            n_fs = 1'b0;
                            n_fce = i_byte[6];
                            n_mode = M_FU_PEND;
                            o_rd.status = ST_TAKEN;
                        end
                    end
                end
                M_FU_PEND, M_FU_ON: begin
                    if (r_mode == M_FU_PEND) begin
                        if (r_fs) begin
                            n_flen = FLW'(5);
                            n_active = 1'b1;
                            n_fstamp = i_ts;
                            n_frhdr = r_fhdr;
                        end
                        n_lseq = i_seq;
                        n_mode = M_FU_ON;
                    end
                    if (n_flen >= FLW'(FRAME_BYTES)) begin
                        n_active = 1'b0;
                        n_flen = '0;
                        n_mode = M_SKIP;
                        o_rd.status = ST_OVERFLOW;
                    end else begin
                        o_fwe = i_acc;
                        o_fwaddr = n_flen[FAW-1:0];
                        n_flen = n_flen + FLW'(1);
                        o_rd.status = ST_TAKEN;
                    end
                    if (i_last && n_mode == M_FU_ON && r_fce) begin
                        n_ready = 1'b1;
                        n_rp = '0;
                        if (!r_ref) begin
                            n_rstamp = n_fstamp;
                            n_ref = 1'b1;
                        end
                    end
                end
                default: o_rd.status = ST_IGNORED;
            endcase
            if (i_last) begin
                n_mode = M_NONE;
            end
        end
        o_rd.ready = n_ready;
    end

    always_comb begin
        o_swe = '0;
        for (int k = 0; k < 4; k++) begin
            if (sw_sc) begin
                o_swaddr[k] = {~r_bank, sc_row[k]};
                o_swdata[k] = sc_dat[k];
            end else begin
                o_swaddr[k] = {~r_bank, r_slen[PAW-1:2]};
                o_swdata[k] = i_byte;
            end
        end
        if (i_acc && sw_sc) begin
            o_swe = 4'hF;
        end else if (i_acc && sw_data) begin
            o_swe[r_slen[1:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NONE; r_phase <= PH_HI; r_fs <= 1'b0; r_fce <= 1'b0;
            r_have <= 1'b0; r_pend <= 1'b0; r_ready <= 1'b0;
            r_active <= 1'b0; r_ref <= 1'b0; r_bank <= 1'b0;
            r_flen <= '0; r_plen <= '0; r_slen <= '0; r_urem <= '0;
            r_lseq <= '0; r_fhdr <= '0; r_frhdr <= '0;
            r_fstamp <= '0; r_rstamp <= '0; r_rp <= '0;
        end else if (i_acc) begin
            r_mode <= n_mode; r_phase <= n_phase; r_fs <= n_fs; r_fce <= n_fce;
            r_have <= n_have; r_pend <= n_pend; r_ready <= n_ready;
            r_active <= n_active; r_ref <= n_ref; r_bank <= n_bank;
            r_flen <= n_flen; r_plen <= n_plen; r_slen <= n_slen; r_urem <= n_urem;
            r_lseq <= n_lseq; r_fhdr <= n_fhdr; r_frhdr <= n_frhdr;
            r_fstamp <= n_fstamp; r_rstamp <= n_rstamp; r_rp <= n_rp;
        end
    end
endmodule

@@ sv/h264_rtp_depacketizer.sv @@
// H.264 RTP depacketizer, STAP-A parameter sets and FU-A frames.
// Input stream: one transfer per item. tuser[0] selects a payload byte (0)
// or a read request (1); tuser[1] flags the first byte of a packet and
// tlast the last one. tdata carries byte, RTP timestamp and sequence.
// Output stream: one transfer per input item with status, Annex-B byte,
// pts and the frame-ready flag; tlast marks the final byte of an access unit.
// Output valid rises once an item has gone through the middle stage into the
// output register. One item is taken every cycle unless the output stalls:
// state updates in the accept cycle, buffer reads land in a registered stage.
// Parameter sets are double banked in four byte-lane RAMs so a start code
// writes all four lanes at once and a finished set is committed by a bank swap.
// Frame bytes live in one RAM of FRAME_BYTES; the start code and NAL header
// are generated on readout.
// Reset clears all control state at once; no clearing pass is needed.
// When the receiver stalls, the output and middle stage hold and the input
// keeps taking items until both stages are full.
module h264_rtp_depacketizer #(
    parameter int FRAME_BYTES = 65536,
    parameter int PARAM_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,  // data_byte, rtp_timestamp, rtp_seq
    input  logic [1:0]  i_s_axis_tuser,  // kind, packet_first
    input  logic        i_s_axis_tlast,  // packet_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // status, out_byte, out_pts, frame_ready
    output logic        o_m_axis_tlast   // out_last
);
    import h264d_pkg::*;

    localparam int FAW = $clog2(FRAME_BYTES);
    localparam int PAW = $clog2(PARAM_BYTES);

    logic acc, adv;
    t_rd  rd, r_rd1;
    logic r_v1;
    logic [PAW-2:0] prd_addr;
    logic [FAW-1:0] frd_addr, fwaddr;
    logic fwe;
    logic [7:0] fwdata, fq, byte1;
    logic [3:0] swe;
    logic [3:0][PAW-2:0] swaddr;
    logic [3:0][7:0] swdata, pq;

    assign adv = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = !r_v1 || adv;
    assign acc = i_s_axis_tvalid && o_s_axis_tready;

    h264d_ctrl #(.FRAME_BYTES(FRAME_BYTES), .PARAM_BYTES(PARAM_BYTES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc(acc),
        .i_kind(i_s_axis_tuser[0]), .i_byte(i_s_axis_tdata[7:0]),
        .i_first(i_s_axis_tuser[1]), .i_last(i_s_axis_tlast),
        .i_ts(i_s_axis_tdata[39:8]), .i_seq(i_s_axis_tdata[55:40]),
        .o_rd(rd), .o_prd_addr(prd_addr), .o_frd_addr(frd_addr),
        .o_fwe(fwe), .o_fwaddr(fwaddr), .o_fwdata(fwdata),
        .o_swe(swe), .o_swaddr(swaddr), .o_swdata(swdata)
    );

    h264d_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
        .i_clk(i_clk), .i_we(fwe), .i_waddr(fwaddr), .i_wdata(fwdata),
        .i_re(acc), .i_raddr(frd_addr), .o_rdata(fq)
    );

    for (genvar k = 0; k < 4; k++) begin : g_lane
        h264d_ram #(.WIDTH(8), .DEPTH(PARAM_BYTES / 2)) u_param_ram (
            .i_clk(i_clk), .i_we(swe[k]), .i_waddr(swaddr[k]), .i_wdata(swdata[k]),
            .i_re(acc), .i_raddr(prd_addr), .o_rdata(pq[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_v1 <= i_s_axis_tvalid;
        end
        if (acc) begin
            r_rd1 <= rd;
        end
    end

    always_comb begin
        unique case (r_rd1.src)
            SRC_PARAM: byte1 = pq[r_rd1.lane];
            SRC_FRAME: byte1 = fq;
            default:   byte1 = r_rd1.cbyte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_axis_tvalid <= 1'b0;
        end else if (adv) begin
            o_m_axis_tvalid <= r_v1;
        end
        if (adv && r_v1) begin
            o_m_axis_tdata <= {4'h0, r_rd1.ready, r_rd1.pts, byte1, r_rd1.status};
            o_m_axis_tlast <= r_rd1.last;
        end
    end
endmodule

@@ sv/h264d_checker.sv @@
module h264d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    import h264d_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output data changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2:0] != 3'd6 && o_m_axis_tdata[2:0] != 3'd7))
        else $error("undefined status code");

    a_last_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata[2:0] == ST_READ &&
        !o_m_axis_tdata[43])
        else $error("last byte without read status or with frame still ready");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[2:0] != ST_READ |->
        o_m_axis_tdata[42:3] == 40'd0)
        else $error("byte or pts set without read status");
endmodule

bind h264_rtp_depacketizer h264d_checker u_h264d_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata(o_m_axis_tdata),
    .o_m_axis_tlast(o_m_axis_tlast)
);

@@ test/tb_h264_rtp_depacketizer.sv @@
`timescale 1ns / 1ps

module tb_h264_rtp_depacketizer;
    import h264d_pkg::*;

    localparam int FRAME_BYTES = 65536;
    localparam int PARAM_BYTES = 256;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        bit        kind;
        bit [7:0]  b;
        bit        first;
        bit        last;
        bit [31:0] ts;
        bit [15:0] seq;
    } rtp_item_t;

    typedef struct {
        bit [2:0]  status;
        bit [7:0]  b;
        bit        last;
        bit [31:0] pts;
        bit        ready;
    } au_byte_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata;  // data_byte, rtp_timestamp, rtp_seq
    logic [1:0]  i_s_axis_tuser;  // kind, packet_first
    logic        i_s_axis_tlast;  // packet_last
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;  // status, out_byte, out_pts, frame_ready
    logic        o_m_axis_tlast;  // out_last

    h264_rtp_depacketizer dut (.*);

    rtp_item_t rtp_items_q[$];
    au_byte_t  au_expect_q[$];
    rtp_item_t cur_item;
    int        send_idle;
    int        recv_idle;
    bit        failed;
    int        cycles;

    // depacketizer state mirror
    bit [7:0]    fr_mem[FRAME_BYTES];
    bit [7:0]    pr_mem[PARAM_BYTES];
    bit [7:0]    stg_mem[PARAM_BYTES];
    int unsigned fr_len, pr_len, stg_len, unit_rem, rd_ptr;
    bit          f_have, f_pend, f_ready, f_active, f_ref;
    bit [31:0]   fr_ts, ref_ts;
    bit [15:0]   last_seq;
    bit [7:0]    fu_hdr;
    t_mode       mode;
    t_phase      phase;
    bit          frag_start, frag_end;

    // generator bookkeeping
    bit [31:0]   gen_ts;
    bit [15:0]   gen_seq;
    int          gen_plen;
    bit          gen_pend;

    function automatic bit [2:0] stap_byte(bit [7:0] b);
        int unsigned len;
        if (phase == PH_DATA && unit_rem == 0)
            phase = PH_HI;
        if (phase == PH_HI) begin
            unit_rem = int'(b) << 8;
            phase = PH_LO;
            return ST_TAKEN;
        end
        if (phase == PH_LO) begin
            len = unit_rem | b;
            if (stg_len + 4 + len > PARAM_BYTES) begin
                mode = M_SKIP;
                return ST_OVERFLOW;
            end
            stg_mem[stg_len] = 0;
            stg_mem[stg_len + 1] = 0;
            stg_mem[stg_len + 2] = 0;
            stg_mem[stg_len + 3] = 1;
            stg_len += 4;
            unit_rem = len;
            phase = PH_DATA;
            return ST_TAKEN;
        end
        if (stg_len < PARAM_BYTES)
            stg_mem[stg_len] = b;
        stg_len++;
        unit_rem--;
        if (unit_rem == 0)
            phase = PH_HI;
        return ST_TAKEN;
    endfunction

    function automatic bit [2:0] fu_header_byte(bit [7:0] b, bit [31:0] ts, bit [15:0] seq);
        bit [7:0] hdr;
        hdr = (fu_hdr & MASK_NRI) | (b & MASK_TYPE);
        fu_hdr = hdr;
        if (!f_have || (f_pend && hdr != HDR_IDR)) begin
            mode = M_SKIP;
            return ST_IGNORED;
        end
        if (b[7]) begin
            frag_start = 1;
            frag_end = 0;
        end else begin
            if (!f_active || seq != last_seq + 16'd1 || ts != fr_ts) begin
                mode = M_SKIP;
                return ST_IGNORED;
            end
            frag_start = 0;
            frag_end = b[6];
        end
        mode = M_FU_PEND;
        return ST_TAKEN;
    endfunction

    function automatic bit [2:0] frame_append(bit [7:0] b);
        if (fr_len >= FRAME_BYTES) begin
            f_active = 0;
            fr_len = 0;
            mode = M_SKIP;
            return ST_OVERFLOW;
        end
        fr_mem[fr_len] = b;
        fr_len++;
        return ST_TAKEN;
    endfunction

    function automatic bit [2:0] payload_byte(rtp_item_t it);
        bit [2:0] st;
        st = ST_IGNORED;
        if (it.first) begin
            if (mode == M_FU_ON) begin
                f_active = 0;
                fr_len = 0;
            end
            fu_hdr = it.b;
            if (it.last) begin
                mode = M_NONE;
                return ST_IGNORED;
            end
            if (it.b[4:0] == NAL_STAP_A) begin
                mode = M_STAP;
                phase = PH_HI;
                stg_len = 0;
                unit_rem = 0;
                return ST_TAKEN;
            end
            mode = (it.b[4:0] == NAL_FU_A) ? M_FU_HDR : M_SKIP;
            return (mode == M_SKIP) ? ST_IGNORED : ST_TAKEN;
        end
        if (mode == M_NONE)
            return ST_IGNORED;
        case (mode)
            M_STAP: begin
                st = stap_byte(it.b);
                if (it.last && mode == M_STAP) begin
                    if (phase == PH_HI && stg_len > 0 && stg_len <= PARAM_BYTES) begin
                        for (int i = 0; i < stg_len; i++)
                            pr_mem[i] = stg_mem[i];
                        pr_len = stg_len;
                        f_have = 1;
                        f_pend = 1;
                    end else begin
                        st = ST_IGNORED;
                    end
                end
            end
            M_FU_HDR: st = it.last ? ST_IGNORED : fu_header_byte(it.b, it.ts, it.seq);
            M_FU_PEND, M_FU_ON: begin
                if (mode == M_FU_PEND) begin
                    if (frag_start) begin
                        fr_mem[0] = 0;
                        fr_mem[1] = 0;
                        fr_mem[2] = 0;
                        fr_mem[3] = 1;
                        fr_mem[4] = fu_hdr;
                        fr_len = 5;
                        f_active = 1;
                        fr_ts = it.ts;
                    end
                    last_seq = it.seq;
                    mode = M_FU_ON;
                end
                st = frame_append(it.b);
                if (it.last && mode == M_FU_ON && frag_end) begin
                    f_ready = 1;
                    rd_ptr = 0;
                    if (!f_ref) begin
                        ref_ts = fr_ts;
                        f_ref = 1;
                    end
                end
            end
            default: st = ST_IGNORED;
        endcase
        if (it.last)
            mode = M_NONE;
        return st;
    endfunction

    function automatic au_byte_t depack_step(rtp_item_t it);
        au_byte_t    r;
        int unsigned plen;
        r = '{default: 0};
        if (it.kind) begin
            if (!f_ready) begin
                r.status = ST_EMPTY;
            end else begin
                plen = f_pend ? pr_len : 0;
                r.b = (rd_ptr < plen) ? pr_mem[rd_ptr] : fr_mem[rd_ptr - plen];
                r.pts = fr_ts - ref_ts;
                r.status = ST_READ;
                if (rd_ptr + 1 >= plen + fr_len) begin
                    r.last = 1;
                    f_ready = 0;
                    f_active = 0;
                    f_pend = 0;
                    fr_len = 0;
                    rd_ptr = 0;
                end else begin
                    rd_ptr++;
                end
            end
        end else if (f_ready) begin
            r.status = ST_BUSY;
        end else begin
            r.status = payload_byte(it);
        end
        r.ready = f_ready;
        return r;
    endfunction

    // stimulus helpers
    task automatic push_item(bit kind, bit [7:0] b, bit first, bit last);
        rtp_items_q.push_back('{kind, b, first, last, gen_ts, gen_seq});
    endtask

    task automatic push_packet(bit [7:0] bytes[$]);
        foreach (bytes[i])
            push_item(0, bytes[i], i == 0, i == bytes.size() - 1);
    endtask

    task automatic push_reads(int n);
        repeat (n)
            push_item(1, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_stap(int units, int maxlen);
        bit [7:0] pk[$];
        int       len, total;
        total = 0;
        pk.push_back({3'($urandom), NAL_STAP_A});
        repeat (units) begin
            len = $urandom_range(1, maxlen);
            pk.push_back(8'(len >> 8));
            pk.push_back(8'(len));
            repeat (len)
                pk.push_back(8'($urandom));
            total += 4 + len;
        end
        gen_seq++;
        push_packet(pk);
        if (total <= PARAM_BYTES) begin
            gen_plen = total;
            gen_pend = 1;
        end
    endtask

    // FU-A frame: start packet then continuations, the final one with the end bit
    task automatic send_frame(int npkts, int maxdata, bit [4:0] ntype, bit [2:0] nri);
        bit [7:0] pk[$];
        int       flen;
        gen_ts = $urandom;
        flen = 5;
        for (int p = 0; p < npkts; p++) begin
            pk = {};
            pk.push_back({nri, NAL_FU_A});
            pk.push_back({p == 0, p == npkts - 1 && p != 0, 1'b0, ntype});
            repeat ($urandom_range(1, maxdata)) begin
                pk.push_back(8'($urandom));
                flen++;
            end
            gen_seq++;
            push_packet(pk);
        end
        if (npkts > 1) begin
            if ($urandom_range(9) == 0)
                push_item(0, 8'($urandom), 1'($urandom), 1'($urandom));
            push_reads((gen_pend ? gen_plen : 0) + flen + $urandom_range(0, 1));
            gen_pend = 0;
        end
    endtask

    task automatic send_noise();
        bit [7:0] pk[$];
        case ($urandom_range(4))
            0: repeat ($urandom_range(1, 6))
                push_item($urandom_range(3) == 0, 8'($urandom), 1'($urandom),
                          1'($urandom));
            1: begin
                // continuation with a broken sequence number
                pk = {8'h7C, 8'h45, 8'($urandom)};
                gen_seq += 16'($urandom_range(2, 9));
                push_packet(pk);
            end
            2: begin
                // cut-off FU-A packet, next start abandons it
                push_item(0, 8'h7C, 1, 0);
                push_item(0, 8'h85, 0, 0);
                push_item(0, 8'($urandom), 0, 0);
            end
            3: begin
                pk = {8'h78, 8'h00, 8'h05, 8'($urandom)};
                push_packet(pk);
            end
            default: push_packet('{8'($urandom), 8'($urandom)});
        endcase
    endtask

    task automatic random_phase(int n_items);
        int target;
        target = rtp_items_q.size() + n_items;
        while (rtp_items_q.size() < target) begin
            case ($urandom_range(9))
                0, 1: send_stap($urandom_range(1, 3), $urandom_range(1, 12));
                2, 3, 4, 5, 6: begin
                    if ($urandom_range(3) == 0)
                        send_stap($urandom_range(1, 2), 8);
                    send_frame($urandom_range(2, 3), 6,
                               ($urandom_range(9) == 0) ? 5'($urandom) : 5'd5,
                               ($urandom_range(9) == 0) ? 3'($urandom) : 3'd3);
                end
                default: send_noise();
            endcase
        end
        while (rtp_items_q.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_s_axis_tlast = 0;
        i_m_axis_tready = 0;
        mode = M_NONE;
        phase = PH_HI;
        send_idle = 31;
        recv_idle = 77;
        gen_ts = 32'hFFFF_FFF0;
        gen_seq = 16'hFFFD;
        gen_plen = 0;
        gen_pend = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: stray byte, one-byte packet, read with nothing ready
        push_item(0, 8'hFF, 0, 1);
        push_item(0, 8'h7C, 1, 1);
        push_item(1, 8'h00, 0, 0);
        // fragment before any parameter set, then a non-handled type
        push_packet('{8'h7C, 8'h85, 8'h01});
        push_packet('{8'h41, 8'hAA, 8'h00});
        // malformed STAP-A: ends after a length field, then cut length
        push_packet('{8'h78, 8'h00, 8'h02});
        push_packet('{8'h78, 8'h00});
        // staging overflow and a set of exactly PARAM_BYTES
        push_packet('{8'h78, 8'h01, 8'h2C, 8'h11, 8'h22});
        send_stap(1, 1);
        push_packet('{8'h78, 8'h00, 8'd252});
        repeat (251) push_item(0, 8'($urandom), 0, 0);
        push_item(0, 8'hEE, 0, 1);
        gen_plen = 256;
        // wrong header while the set is pending, two-byte FU-A packet
        push_packet('{8'h5C, 8'h81, 8'h10});
        push_packet('{8'h7C, 8'h85});
        send_frame(3, 3, 5'd5, 3'd3);
        random_phase(300);

        send_idle = 77;
        recv_idle = 31;
        random_phase(300);

        send_idle = 0;
        recv_idle = 0;
        random_phase(300);

        while (au_expect_q.size() > 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed && au_expect_q.size() == 0)
            $display("h264_rtp_depacketizer test passed");
        else
            $display("h264_rtp_depacketizer test failed");
        $finish;
    end

    // driver: predict on each transfer, then present the next item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                au_expect_q.push_back(depack_step(cur_item));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (rtp_items_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_item = rtp_items_q.pop_front();
                    i_s_axis_tdata <= {cur_item.seq, cur_item.ts, cur_item.b};
                    i_s_axis_tuser <= {cur_item.first, cur_item.kind};
                    i_s_axis_tlast <= cur_item.last;
                    i_s_axis_tvalid <= 1;
                end else begin
                    i_s_axis_tvalid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        au_byte_t e;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (au_expect_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_m_axis_tdata);
                    failed = 1;
                end else begin
                    e = au_expect_q.pop_front();
                    if (o_m_axis_tdata[2:0] !== e.status) begin
                        $display("%0t: status exp %0d got %0d", $time, e.status,
                                 o_m_axis_tdata[2:0]);
                        failed = 1;
                    end
                    if (o_m_axis_tdata[10:3] !== e.b) begin
                        $display("%0t: byte exp %h got %h", $time, e.b, o_m_axis_tdata[10:3]);
                        failed = 1;
                    end
                    if (o_m_axis_tdata[42:11] !== e.pts) begin
                        $display("%0t: pts exp %h got %h", $time, e.pts,
                                 o_m_axis_tdata[42:11]);
                        failed = 1;
                    end
                    if (o_m_axis_tdata[43] !== e.ready) begin
                        $display("%0t: ready exp %b got %b", $time, e.ready,
                                 o_m_axis_tdata[43]);
                        failed = 1;
                    end
                    if (o_m_axis_tlast !== e.last) begin
                        $display("%0t: last exp %b got %b", $time, e.last, o_m_axis_tlast);
                        failed = 1;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("h264_rtp_depacketizer test failed");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
sv/h264d_pkg.sv
sv/h264d_ram.sv
sv/h264d_ctrl.sv
sv/h264_rtp_depacketizer.sv
sv/h264d_checker.sv
test/tb_h264_rtp_depacketizer.sv
